// File: src/sorted_list_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted list table: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted_list_table: same-cycle check failed");
// next-cycle implication
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_list_table: next-cycle check failed");
`else
`define SLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/slt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list table: package
// Sizes, opcodes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY  = 64;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OP_W      = 2;
	localparam int IDX_W     = 6;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;
	localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	// read address select
	localparam logic [1:0] RA_PTR  = 2'd0;
	localparam logic [1:0] RA_PREV = 2'd1;
	localparam logic [1:0] RA_NEXT = 2'd2;

	// pointer update
	localparam logic [1:0] PTR_HOLD = 2'd0;
	localparam logic [1:0] PTR_DEC  = 2'd1;
	localparam logic [1:0] PTR_INC  = 2'd2;

	// count update
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	typedef struct packed {
		logic       load;      // capture the incoming item
		logic       rd_en;     // memory read
		logic [1:0] rd_sel;    // read address select
		logic       wr_en;     // memory write at pointer
		logic       wr_value;  // 1: write held value, 0: write read data
		logic [1:0] ptr_op;
		logic [1:0] cnt_op;
		logic       res_set;   // update result ok/data
		logic       res_ok;
		logic       res_rdata; // result data from read data, else zero
		logic       out_load;  // move result into output register
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            idx_ok;
		logic            ptr_zero;
		logic            ptr_last;
		logic            val_less;
		logic            out_free;
	} sts_t;

endpackage

// File: src/slt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list table: controller
// Sequences the insert shift, delete close-up, read and clear operations.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  slt_pkg::sts_t sts,
	output slt_pkg::cmd_t cmd
);
	import slt_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DISP    = 3'd1;
	localparam logic [2:0] S_INS_RD  = 3'd2;
	localparam logic [2:0] S_INS_CMP = 3'd3;
	localparam logic [2:0] S_GET     = 3'd4;
	localparam logic [2:0] S_DEL_RD  = 3'd5;
	localparam logic [2:0] S_DEL_WR  = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.full) begin
							cmd.res_set = 1'b1;
							state_d     = S_DONE;
						end else begin
							state_d = S_INS_RD;
						end
					end
					OP_DELETE, OP_READ: begin
						if (!sts.idx_ok) begin
							cmd.res_set = 1'b1;
							state_d     = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_PTR;
							state_d    = S_GET;
						end
					end
					default: begin
						cmd.cnt_op  = CNT_CLR;
						cmd.res_set = 1'b1;
						cmd.res_ok  = 1'b1;
						state_d     = S_DONE;
					end
				endcase
			end
			// look at the entry below the gap, or fill the bottom
			S_INS_RD: begin
				if (sts.ptr_zero) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_value = 1'b1;
					cmd.cnt_op   = CNT_INC;
					cmd.res_set  = 1'b1;
					cmd.res_ok   = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PREV;
					state_d    = S_INS_CMP;
				end
			end
			// larger entry moves up, else the new value lands in the gap
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.val_less) begin
					cmd.ptr_op = PTR_DEC;
					state_d    = S_INS_RD;
				end else begin
					cmd.wr_value = 1'b1;
					cmd.cnt_op   = CNT_INC;
					cmd.res_set  = 1'b1;
					cmd.res_ok   = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_GET: begin
				cmd.res_set   = 1'b1;
				cmd.res_ok    = 1'b1;
				cmd.res_rdata = 1'b1;
				state_d       = (sts.op == OP_DELETE) ? S_DEL_RD : S_DONE;
			end
			// close the gap one entry at a time
			S_DEL_RD: begin
				if (sts.ptr_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_NEXT;
					state_d    = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.ptr_op = PTR_INC;
				state_d    = S_DEL_RD;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/slt_datapath.sv
// ----------------------------------------------------------------------------
// Sorted list table: datapath
// Entry memory, count, pointer, result and output registers.
// ----------------------------------------------------------------------------
`include "sorted_list_table_defines.svh"

module slt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [slt_pkg::OP_W-1:0]          opcode,
	input  logic [slt_pkg::IDX_W-1:0]         index,
	input  logic signed [slt_pkg::VAL_W-1:0]  value,
	input  slt_pkg::cmd_t                     cmd,
	output slt_pkg::sts_t                     sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              ok,
	output logic signed [slt_pkg::VAL_W-1:0]  data_out,
	output logic [slt_pkg::CNT_OUT_W-1:0]     count
);
	import slt_pkg::*;

	logic [VAL_W-1:0]  mem [CAPACITY];

	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VAL_W-1:0]  value_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [VAL_W-1:0]  rdata_q;
	logic              ok_q;
	logic [VAL_W-1:0]  data_q;
	logic              out_valid_q;
	logic              out_ok_q;
	logic [VAL_W-1:0]  out_data_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  wdata;

	// read address around the pointer
	always_comb begin
		case (cmd.rd_sel)
			RA_PREV: rd_addr = ptr_q - ADDR_W'(1);
			RA_NEXT: rd_addr = ptr_q + ADDR_W'(1);
			default: rd_addr = ptr_q;
		endcase
	end

	assign wdata = cmd.wr_value ? value_q : rdata_q;

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[ptr_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// captured item, pointer and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			idx_q   <= index;
			value_q <= value;
			ptr_q   <= (opcode == OP_INSERT) ? ADDR_W'(count_q) : ADDR_W'(index);
		end else begin
			case (cmd.ptr_op)
				PTR_DEC: ptr_q <= ptr_q - ADDR_W'(1);
				PTR_INC: ptr_q <= ptr_q + ADDR_W'(1);
				default: ptr_q <= ptr_q;
			endcase
		end
		if (cmd.res_set) begin
			ok_q   <= cmd.res_ok;
			data_q <= cmd.res_rdata ? rdata_q : '0;
		end
		if (cmd.out_load) begin
			out_ok_q    <= ok_q;
			out_data_q  <= data_q;
			out_count_q <= CNT_OUT_W'(count_q);
		end
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status to the controller
	assign sts.op       = op_q;
	assign sts.full     = (count_q == CNT_W'(CAPACITY));
	assign sts.idx_ok   = (CMP_W'(idx_q) < CMP_W'(count_q));
	assign sts.ptr_zero = (ptr_q == '0);
	assign sts.ptr_last = ((CNT_W'(ptr_q) + CNT_W'(1)) >= count_q);
	assign sts.val_less = ($signed(value_q) < $signed(rdata_q));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign ok        = out_ok_q;
	assign data_out  = out_data_q;
	assign count     = out_count_q;

	`SLT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLT_ASSERT_NEXT(a_count_inc, clk, arst_n, cmd.cnt_op == CNT_INC && !sts.full, count_q == $past(count_q) + CNT_W'(1))
	`SLT_ASSERT_IMP(a_out_slot_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)

endmodule

// File: src/sorted_list_table.sv
// Operation: read, clear and refused operations need no shifting; insert moves each larger
//   entry up by one, with one read and one write per entry moved, before the new value lands,
//   and delete moves each later entry down the same way. One memory port pair sets the pace.
// Throughput: one operation at a time, the next accepted once the result has moved into the
//   output register; a waiting result blocks the next operation until the output is free.
// Reset: arst_n clears the count and the output valid; entry contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted list table: top level
// Ascending list of signed values with insert, delete, read and clear.
// ----------------------------------------------------------------------------
module sorted_list_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // opcode[1:0], index[7:2], value[39:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // ok[0], data_out[32:1], count[39:33]
);
	import slt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic                    ok;
	logic signed [VAL_W-1:0] data_out;
	logic [CNT_OUT_W-1:0]    count;

	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.opcode    (s_axis_tdata[1:0]),
		.index     (s_axis_tdata[7:2]),
		.value     ($signed(s_axis_tdata[39:8])),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ok        (ok),
		.data_out  (data_out),
		.count     (count)
	);

	assign m_axis_tdata = {count, data_out, ok};

endmodule

// File: dv/tb_sorted_list_table.sv
// ----------------------------------------------------------------------------
// Sorted list table: testbench
// Streams insert, delete, read and clear operations into the table and checks
// every returned status against a local model of the ascending list. A short
// directed pass covers the corners. Random episodes then fill the table to
// overflow, drain it, mix operations and inject noise. Both stream sides idle
// at random.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int TAIL_CYCLES  = 150;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic [1:0]  opcode;
		logic [5:0]  index;
		logic [31:0] value;
		bit          wait_idle;  // hold off until every outstanding result is back
	} table_op_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] data;
		logic [6:0]  count;
	} table_result_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BUSY} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // opcode[1:0], index[7:2], value[39:8]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // ok[0], data_out[32:1], count[39:33]

	// stimulus and expectations
	table_op_t     ops_pending[$];
	table_result_t table_results_due[$];
	int            shadow_count = 0;   // list size as seen by the stimulus generator

	// local copy of the list
	logic signed [31:0] sorted_vals [CAPACITY];
	int                 stored = 0;

	int         mismatches = 0;
	int         cycles = 0;
	int         burst_left;
	int         gap_left;
	table_op_t  head_op;
	sink_mode_t sink_mode;
	int         sink_left;
	logic [7:0] sink_phase;

	sorted_list_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// apply one operation to the local list and return the status it gives
	function automatic table_result_t apply_table_op(input logic [1:0] opc,
			input logic [5:0] idx, input logic signed [31:0] val);
		table_result_t res;
		int pos;
		res.ok   = 1'b0;
		res.data = '0;
		case (opc)
			OP_INSERT: begin
				if (stored < CAPACITY) begin
					// land after every entry not greater than the new value
					pos = 0;
					for (int i = 0; i < stored; i++)
						if (sorted_vals[i] <= val) pos++;
					for (int i = stored; i > pos; i--)
						sorted_vals[i] = sorted_vals[i - 1];
					sorted_vals[pos] = val;
					stored++;
					res.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (int'(idx) < stored) begin
					res.data = sorted_vals[idx];
					for (int i = idx; i < stored - 1; i++)
						sorted_vals[i] = sorted_vals[i + 1];
					stored--;
					res.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (int'(idx) < stored) begin
					res.data = sorted_vals[idx];
					res.ok   = 1'b1;
				end
			end
			default: begin
				stored = 0;
				res.ok = 1'b1;
			end
		endcase
		res.count = 7'(stored);
		return res;
	endfunction

	task automatic add_op(input logic [1:0] opc, input logic [5:0] idx,
			input logic [31:0] val, input bit hold);
		table_op_t op;
		op.opcode    = opc;
		op.index     = idx;
		op.value     = val;
		op.wait_idle = hold;
		ops_pending.push_back(op);
		case (opc)
			OP_INSERT: if (shadow_count < CAPACITY) shadow_count++;
			OP_DELETE: if (int'(idx) < shadow_count) shadow_count--;
			OP_CLEAR:  shadow_count = 0;
			default: ;
		endcase
	endtask

	// corners, a narrow band for duplicates, otherwise anything
	function automatic logic [31:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 11);
		if (sel == 0) return 32'h7fff_ffff;
		if (sel == 1) return 32'h8000_0000;
		if (sel < 5) return 32'($urandom_range(0, 16)) - 32'd8;
		return $urandom();
	endfunction

	function automatic logic [5:0] good_index();
		if (shadow_count == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, shadow_count - 1));
	endfunction

	function automatic logic [5:0] bad_index();
		if (shadow_count >= CAPACITY) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(shadow_count, 63));
	endfunction

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
	endtask

	// stimulus, reset and end of run
	initial begin
		int  kind;
		int  span;
		int  roll;
		int  random_count;
		bit  hold;

		// directed corners
		add_op(OP_READ,   6'd0,  32'd0,         1'b0);  // read on empty list
		add_op(OP_DELETE, 6'd0,  32'd0,         1'b0);  // delete on empty list
		add_op(OP_READ,   6'd63, 32'hffff_ffff, 1'b0);
		add_op(OP_INSERT, 6'd0,  32'd0,         1'b0);
		add_op(OP_INSERT, 6'd63, 32'h7fff_ffff, 1'b0);
		add_op(OP_INSERT, 6'd0,  32'h8000_0000, 1'b0);
		add_op(OP_INSERT, 6'd0,  32'hffff_ffff, 1'b0);
		add_op(OP_INSERT, 6'd0,  32'd0,         1'b0);  // equal value goes behind
		add_op(OP_INSERT, 6'd0,  32'd5,         1'b0);
		add_op(OP_READ,   6'd0,  32'd0,         1'b0);
		add_op(OP_READ,   6'd5,  32'd0,         1'b0);
		add_op(OP_READ,   6'd6,  32'd0,         1'b0);  // index equal to count
		add_op(OP_READ,   6'd63, 32'd0,         1'b0);
		add_op(OP_DELETE, 6'd5,  32'd0,         1'b0);  // last entry
		add_op(OP_DELETE, 6'd0,  32'd0,         1'b0);  // first entry
		add_op(OP_DELETE, 6'd1,  32'd0,         1'b0);  // middle entry
		add_op(OP_READ,   6'd1,  32'd0,         1'b0);
		add_op(OP_CLEAR,  6'd0,  32'd0,         1'b1);
		add_op(OP_READ,   6'd0,  32'd0,         1'b0);
		add_op(OP_CLEAR,  6'd63, 32'hffff_ffff, 1'b0);  // clear when already empty
		add_op(OP_INSERT, 6'd0,  32'h7fff_ffff, 1'b0);
		add_op(OP_INSERT, 6'd0,  32'h7fff_ffff, 1'b0);
		add_op(OP_DELETE, 6'd63, 32'd0,         1'b0);
		add_op(OP_DELETE, 6'd0,  32'd0,         1'b0);

		// random episodes
		random_count = 0;
		hold = 1'b1;
		while (random_count < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 0)
				span = CAPACITY - shadow_count + $urandom_range(1, 4);
			else if (kind == 9)
				span = 1;
			else
				span = $urandom_range(5, 60);
			for (int n = 0; n < span; n++) begin
				roll = $urandom_range(0, 99);
				if (kind == 0) begin
					// fill to the top and knock on the full list
					add_op(OP_INSERT, 6'($urandom_range(0, 63)), pick_value(), hold);
				end else if (kind <= 3) begin
					if (roll < 85)
						add_op(OP_INSERT, 6'($urandom_range(0, 63)), pick_value(), hold);
					else
						add_op(OP_READ, good_index(), $urandom(), hold);
				end else if (kind <= 5) begin
					if (roll < 80)
						add_op(OP_DELETE, good_index(), $urandom(), hold);
					else if (roll < 90)
						add_op(OP_DELETE, bad_index(), $urandom(), hold);
					else
						add_op(OP_READ, good_index(), $urandom(), hold);
				end else if (kind <= 7) begin
					if (roll < 35)
						add_op(OP_INSERT, 6'($urandom_range(0, 63)), pick_value(), hold);
					else if (roll < 55)
						add_op(OP_DELETE, good_index(), $urandom(), hold);
					else if (roll < 60)
						add_op(OP_DELETE, bad_index(), $urandom(), hold);
					else if (roll < 90)
						add_op(OP_READ, good_index(), $urandom(), hold);
					else if (roll < 97)
						add_op(OP_READ, bad_index(), $urandom(), hold);
					else
						add_op(OP_CLEAR, 6'($urandom_range(0, 63)), $urandom(), hold);
				end else if (kind == 8) begin
					add_op(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
						$urandom(), hold);
				end else begin
					add_op(OP_CLEAR, 6'($urandom_range(0, 63)), $urandom(), hold);
				end
				hold = 1'b0;
				random_count++;
			end
			hold = ($urandom_range(0, 3) == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ops_pending.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (table_results_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && table_results_due.size() == 0)
			$display("tb_sorted_list_table: clean");
		else
			$display("tb_sorted_list_table: errors");
		$finish;
	end

	// sender: bursts of operations with random gaps, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left    <= 1;
			gap_left      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				table_results_due.push_back(apply_table_op(s_axis_tdata[1:0],
					s_axis_tdata[7:2], s_axis_tdata[39:8]));
			if (s_axis_tvalid && !s_axis_tready) begin
				// transfer not taken yet: hold
			end else if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left      <= gap_left - 1;
			end else if (ops_pending.size() != 0 &&
					!(ops_pending[0].wait_idle && table_results_due.size() != 0)) begin
				head_op = ops_pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {head_op.value, head_op.index, head_op.opcode};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches between randomly chosen modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_mode     <= SINK_OPEN;
			sink_left     <= 0;
			sink_phase    <= '0;
		end else begin
			if (sink_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 3));
				sink_left <= $urandom_range(20, 300);
			end else begin
				sink_left <= sink_left - 1;
			end
			sink_phase <= sink_phase + 8'd1;
			case (sink_mode)
				SINK_OPEN:   m_axis_tready <= 1'b1;
				SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
				SINK_SPARSE: m_axis_tready <= (sink_phase[2:0] == 3'd0);
				default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		table_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.ok    = m_axis_tdata[0];
			got.data  = m_axis_tdata[32:1];
			got.count = m_axis_tdata[39:33];
			if (table_results_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result ok=%0b data=%0d count=%0d",
					got.ok, $signed(got.data), got.count));
			end else begin
				want = table_results_due.pop_front();
				if (got !== want)
					log_mismatch($sformatf(
						"exp ok=%0b data=%0d count=%0d, got ok=%0b data=%0d count=%0d",
						want.ok, $signed(want.data), want.count,
						got.ok, $signed(got.data), got.count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("tb_sorted_list_table: errors");
			$finish;
		end
	end

endmodule
